/* rtl/smht_pkg.sv */
// ----------------------------------------------------------------------------
// smht_pkg: shared types and constants of the minute-hand stepper tracker
// Input word layout, half-step coil table and fixed time constants.
// ----------------------------------------------------------------------------
package smht_pkg;

  // Fixed field widths
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int COIL_W   = 4;
  localparam int PHASE_W  = 3;
  localparam int HAND_W   = 11;
  localparam int SECS_W   = 12;

  // Time constants
  localparam int SECS_PER_MIN  = 60;
  localparam int SECS_PER_HOUR = 3600;

  // Command codes
  localparam logic CMD_TRACK = 1'b0;
  localparam logic CMD_STOP  = 1'b1;

  // One input word as held in the input register
  typedef struct packed {
    logic                command;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } item_t;

  // Half-step coil pattern per phase, bit0 = first coil
  function automatic logic [COIL_W-1:0] coil_of(input logic [PHASE_W-1:0] ph);
    logic [COIL_W-1:0] pat;
    case (ph)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'hC;
      3'd6:    pat = 4'h8;
      3'd7:    pat = 4'h9;
      default: pat = 4'h0;
    endcase
    return pat;
  endfunction

endpackage

/* rtl/smht_in_stage.sv */
// ----------------------------------------------------------------------------
// smht_in_stage: input register
// Captures one word from the slave side and holds it until the stepper takes it.
// ----------------------------------------------------------------------------
module smht_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [15:0]    s_tdata,   // [5:0] minute, [11:6] second, [15:12] zero
  input  logic [0:0]     s_tuser,   // [0] command
  input  logic           take,
  output logic           valid,
  output smht_pkg::item_t item
);

  logic load;

  // Accept when empty or when the held word moves on this cycle
  assign s_tready = !valid || take;
  assign load     = s_tvalid && s_tready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  // Hold the payload
  always_ff @(posedge clk) begin
    if (load) begin
      item.command <= s_tuser[0];
      item.minute  <= s_tdata[5:0];
      item.second  <= s_tdata[11:6];
    end
  end

endmodule

/* rtl/smht_stepper.sv */
// ----------------------------------------------------------------------------
// smht_stepper: target compare, half-step update and result register
// Compares the scaled time against the stored position without a divider and
// takes at most one half-step per word.
// ----------------------------------------------------------------------------
module smht_stepper #(
  parameter int STEPS_PER_HOUR = 2048
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  smht_pkg::item_t                in_item,
  output logic                           take,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [smht_pkg::COIL_W-1:0]    out_coil,
  output logic                           out_stepped,
  output logic                           out_forward,
  output logic [smht_pkg::HAND_W-1:0]    out_hand
);

  localparam int PW = $clog2(STEPS_PER_HOUR);
  localparam int CW = smht_pkg::SECS_W + PW + 2;
  localparam int MW = (PW > smht_pkg::HAND_W) ? PW : smht_pkg::HAND_W;
  localparam logic [PW-1:0] POS_LAST = PW'(STEPS_PER_HOUR - 1);

  logic [PW-1:0]                 position;
  logic [PW-1:0]                 position_next;
  logic [smht_pkg::PHASE_W-1:0]  phase;
  logic [smht_pkg::PHASE_W-1:0]  phase_next;
  logic [smht_pkg::COIL_W-1:0]   coil_hold;
  logic [smht_pkg::COIL_W-1:0]   coil_hold_next;

  logic [CW-1:0] secs;
  logic [CW-1:0] scaled;
  logic [CW-1:0] pos_lo;
  logic [CW-1:0] pos_hi;
  logic          go_fwd;
  logic          go_back;
  logic          do_step;
  logic          load;
  logic [MW-1:0] pos_wide;

  // Move a word when the result register is free or being emptied
  assign take = !out_valid || out_ready;
  assign load = in_valid && take;

  // Scale the time: target = floor(scaled / 3600)
  assign secs   = CW'(in_item.minute) * CW'(smht_pkg::SECS_PER_MIN) + CW'(in_item.second);
  assign scaled = secs * CW'(STEPS_PER_HOUR);

  // Position window [pos*3600, (pos+1)*3600) holds exactly the matching targets
  assign pos_lo = CW'(position) * CW'(smht_pkg::SECS_PER_HOUR);
  assign pos_hi = pos_lo + CW'(smht_pkg::SECS_PER_HOUR);

  assign go_fwd  = (in_item.command == smht_pkg::CMD_TRACK) && (scaled >= pos_hi);
  assign go_back = (in_item.command == smht_pkg::CMD_TRACK) && (scaled < pos_lo);
  assign do_step = go_fwd || go_back;

  // Advance or retreat one half-step, wrap position and phase; a stop word clears the coils
  always_comb begin
    position_next  = position;
    phase_next     = phase;
    coil_hold_next = coil_hold;
    if (in_item.command == smht_pkg::CMD_STOP) begin
      coil_hold_next = '0;
    end else if (go_fwd) begin
      position_next  = (position == POS_LAST) ? '0 : position + PW'(1);
      phase_next     = phase + smht_pkg::PHASE_W'(1);
      coil_hold_next = smht_pkg::coil_of(phase + smht_pkg::PHASE_W'(1));
    end else if (go_back) begin
      position_next  = (position == '0) ? POS_LAST : position - PW'(1);
      phase_next     = phase - smht_pkg::PHASE_W'(1);
      coil_hold_next = smht_pkg::coil_of(phase - smht_pkg::PHASE_W'(1));
    end
  end

  // Update state as the word leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= '0;
      phase     <= '0;
      coil_hold <= '0;
    end else if (load) begin
      position  <= position_next;
      phase     <= phase_next;
      coil_hold <= coil_hold_next;
    end
  end

  // Result register occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  assign pos_wide = MW'(position_next);

  always_ff @(posedge clk) begin
    if (load) begin
      out_coil    <= coil_hold_next;
      out_stepped <= do_step;
      out_forward <= go_fwd;
      out_hand    <= pos_wide[smht_pkg::HAND_W-1:0];
    end
  end

  // A forward flag only comes with a step
  a_fwd_implies_step: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_forward || out_stepped))
    else $error("step_forward set without a step");

  // A stop word leaves the coils off
  a_stop_coils_off: assert property (@(posedge clk) disable iff (rst)
    (load && (in_item.command == smht_pkg::CMD_STOP)) |=> (out_coil == '0 && coil_hold == '0))
    else $error("coils not off after stop");

  // Position stays inside one revolution
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    position <= POS_LAST)
    else $error("position out of range");

  // Energized coils always match the current phase
  a_coil_phase: assert property (@(posedge clk) disable iff (rst)
    (coil_hold != '0) |-> (coil_hold == smht_pkg::coil_of(phase)))
    else $error("coil pattern does not match phase");

endmodule

/* rtl/stepper_minute_hand_tracker_top.sv */
// ----------------------------------------------------------------------------
// stepper_minute_hand_tracker_top: minute-hand half-step tracker
// Follows the minute hand with at most one half-step per word toward the target
// derived from minute and second.
//
//   channel  dir  tdata bits                                      tuser
//   s_*      in   [5:0] minute, [11:6] second                     [0] command
//   m_*      out  [3:0] coil, [4] stepped, [5] fwd, [16:6] hand   -
//
// One word per cycle sustained while m_tready stays high; a taken word
// waits in the input register, then loads the result register, where
// its result shows on m_tvalid.
// The position compare, scaling and phase update sit between those registers.
// Reset (rst, synchronous) empties both registers and sets position, phase
// and coils to zero. A stalled m_tready holds the result and backs up into
// s_tready once the input register is also full.
// ----------------------------------------------------------------------------
module stepper_minute_hand_tracker_top #(
  parameter int STEPS_PER_HOUR = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [5:0] minute, [11:6] second, [15:12] zero
  input  logic [0:0]  s_tuser,   // [0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [3:0] coil_pattern, [4] stepped,
                                 // [5] step_forward, [16:6] hand_position,
                                 // [23:17] zero
);

  logic                         take;
  logic                         in_valid;
  smht_pkg::item_t              in_item;
  logic [smht_pkg::COIL_W-1:0]  coil;
  logic                         stepped;
  logic                         forward;
  logic [smht_pkg::HAND_W-1:0]  hand;

  // Input register
  smht_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .take     (take),
    .valid    (in_valid),
    .item     (in_item)
  );

  // Step logic and result register
  smht_stepper #(
    .STEPS_PER_HOUR (STEPS_PER_HOUR)
  ) u_step (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_item     (in_item),
    .take        (take),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_coil    (coil),
    .out_stepped (stepped),
    .out_forward (forward),
    .out_hand    (hand)
  );

  // Pack the result word
  assign m_tdata = {7'd0, hand, forward, stepped, coil};

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb: regression bench for the minute-hand stepper tracker
// Streams minute/second words into the tracker and tracks the hand's
// position, half-step phase and held coils alongside it. Every result word
// is checked field by field against the queued prediction, with random
// gaps and stalls on both sides, a long receiver hold-off, and long climbs
// with minutes past 59 that keep the hand stepping forward.
// ----------------------------------------------------------------------------
module tb;

  localparam int STEPS      = 2048;
  localparam int QUIET_MAX  = 1000;
  localparam int HOLD_LEN   = 60;
  localparam int RAND_WORDS = 1000;
  localparam int SWEEP_LEN  = 300;

  // Half-step coil drive per phase, bit0 = first coil
  localparam logic [smht_pkg::COIL_W-1:0] HALF_STEP_COILS [8] = '{
    4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
  };

  // Result word layout, lowest field last
  typedef struct packed {
    logic [smht_pkg::HAND_W-1:0] hand;
    logic                        fwd;
    logic                        stepped;
    logic [smht_pkg::COIL_W-1:0] coil;
  } hand_result_t;

  // Tracks the hand and holds the results it must show, oldest first
  class hand_scoreboard;
    int unsigned                 steps;
    int unsigned                 position;
    logic [2:0]                  phase;
    logic [smht_pkg::COIL_W-1:0] coil_hold;
    hand_result_t                expected_q[$];
    int errors, n_words, n_results, n_stops, n_fwd, n_back, n_wraps;

    function new(int unsigned steps_per_hour);
      steps     = steps_per_hour;
      position  = 0;
      phase     = 3'd0;
      coil_hold = '0;
      errors    = 0;
      n_words   = 0;
      n_results = 0;
      n_stops   = 0;
      n_fwd     = 0;
      n_back    = 0;
      n_wraps   = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Advance the hand for one accepted word and queue its result
    function void note_word(logic cmd, logic [smht_pkg::MINUTE_W-1:0] minute,
                            logic [smht_pkg::SECOND_W-1:0] second);
      longint unsigned secs;
      longint unsigned target;
      hand_result_t    want;
      want.stepped = 1'b0;
      want.fwd     = 1'b0;
      n_words++;
      if (cmd == smht_pkg::CMD_STOP) begin
        coil_hold = '0;
        n_stops++;
      end else begin
        secs   = minute;
        secs   = secs * smht_pkg::SECS_PER_MIN + second;
        target = secs * steps / smht_pkg::SECS_PER_HOUR;
        if (target != position) begin
          want.stepped = 1'b1;
          if (target > position) begin
            want.fwd = 1'b1;
            phase    = phase + 3'd1;
            n_fwd++;
            if (position == steps - 1) begin
              position = 0;
              n_wraps++;
            end else begin
              position++;
            end
          end else begin
            phase = phase - 3'd1;
            n_back++;
            position = (position == 0) ? steps - 1 : position - 1;
          end
          coil_hold = HALF_STEP_COILS[phase];
        end
      end
      want.coil = coil_hold;
      want.hand = position[smht_pkg::HAND_W-1:0];
      expected_q.push_back(want);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      if (errors < 40) begin
        $display("[%0t] mismatch on %s at result %0d: got %0h, expected %0h",
                 $time, what, n_results, got, want);
      end
      errors++;
    endtask

    // Compare one accepted result word with the oldest prediction
    task check_result(logic [23:0] word);
      hand_result_t got;
      hand_result_t want;
      got = word[16:0];
      n_results++;
      if (expected_q.size() == 0) begin
        report("result with nothing pending", word, 0);
        return;
      end
      want = expected_q.pop_front();
      if (got.coil !== want.coil)       report("coil_pattern", got.coil, want.coil);
      if (got.stepped !== want.stepped) report("stepped", got.stepped, want.stepped);
      if (got.fwd !== want.fwd)         report("step_forward", got.fwd, want.fwd);
      if (got.hand !== want.hand)       report("hand_position", got.hand, want.hand);
    endtask
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;  // [5:0] minute, [11:6] second, [15:12] zero
  logic [0:0]  s_tuser  = '0;  // [0] command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // [3:0] coil, [4] stepped, [5] fwd, [16:6] hand

  hand_scoreboard sb = new(STEPS);

  bit src_idle  = 1'b0;
  bit snk_idle  = 1'b0;
  bit hold_go   = 1'b0;
  int sent      = 0;
  int hold_left = 0;
  int stall_left = 0;
  int quiet     = 0;

  stepper_minute_hand_tracker_top #(.STEPS_PER_HOUR(STEPS)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stall after each word, plus a long hold-off on request
  always @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      stall_left = snk_idle ? $urandom_range(0, 5) : 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end
    if (hold_go) begin
      hold_left = HOLD_LEN;
      hold_go   = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
    end
    m_tready <= !rst && stall_left == 0 && hold_left == 0;
  end

  // Check every accepted result word
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_result(m_tdata);
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_MAX) begin
      $display("watchdog: no word moved for %0d cycles, %0d results pending",
               quiet, sb.pending());
      $display("stepper_minute_hand_tracker_top regression: fail");
      $finish;
    end
  end

  function automatic logic [5:0] any6();
    return 6'($urandom_range(0, 63));
  endfunction

  // Offer one word after a random gap and hold it until taken
  task automatic send_word(logic cmd, logic [smht_pkg::MINUTE_W-1:0] minute,
                           logic [smht_pkg::SECOND_W-1:0] second);
    int gap;
    gap = src_idle ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, second, minute};
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_tready);
    sb.note_word(cmd, minute, second);
    sent++;
  endtask

  // Pause the sender until every pending result has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Walk the clock forward or backward from a random time, rare stops
  task automatic run_tracking(int len, bit backward);
    int t;
    int k;
    t = $urandom_range(0, smht_pkg::SECS_PER_HOUR - 1);
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 15) == 0) begin
        send_word(smht_pkg::CMD_STOP, any6(), any6());
      end else begin
        send_word(smht_pkg::CMD_TRACK, 6'(t / smht_pkg::SECS_PER_MIN),
                  6'(t % smht_pkg::SECS_PER_MIN));
      end
      if (backward) begin
        t = (t + smht_pkg::SECS_PER_HOUR - $urandom_range(0, 3)) % smht_pkg::SECS_PER_HOUR;
      end else begin
        t = (t + $urandom_range(0, 3)) % smht_pkg::SECS_PER_HOUR;
      end
    end
  endtask

  // Minutes past 59 put the target beyond the last step, so the hand climbs
  task automatic climb(int len);
    int k;
    for (k = 0; k < len; k++) begin
      send_word(smht_pkg::CMD_TRACK, 6'($urandom_range(60, 63)), any6());
    end
  endtask

  initial begin
    int seq;
    int k;
    int t;
    int stop_target;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: no step, first step, hold, stop, coils dark until next step
    src_idle = 1'b1;
    snk_idle = 1'b1;
    send_word(smht_pkg::CMD_TRACK, 6'd0, 6'd0);
    send_word(smht_pkg::CMD_TRACK, 6'd0, 6'd2);
    send_word(smht_pkg::CMD_TRACK, 6'd0, 6'd2);
    send_word(smht_pkg::CMD_STOP, 6'd63, 6'd63);
    send_word(smht_pkg::CMD_TRACK, 6'd0, 6'd2);
    send_word(smht_pkg::CMD_TRACK, 6'd0, 6'd0);
    // Field extremes, including minute and second past 59
    send_word(smht_pkg::CMD_TRACK, 6'd59, 6'd59);
    send_word(smht_pkg::CMD_TRACK, 6'd63, 6'd63);
    send_word(smht_pkg::CMD_TRACK, 6'd60, 6'd0);
    send_word(smht_pkg::CMD_TRACK, 6'd0, 6'd63);
    send_word(smht_pkg::CMD_STOP, 6'd0, 6'd0);
    send_word(smht_pkg::CMD_STOP, 6'd42, 6'd21);
    // Step back home and hold there, then one step forward and one back
    for (k = 0; k < 6; k++) send_word(smht_pkg::CMD_TRACK, 6'd0, 6'd0);
    send_word(smht_pkg::CMD_TRACK, 6'd21, 6'd42);
    send_word(smht_pkg::CMD_TRACK, 6'd0, 6'd1);
    drain();

    // Random sequences, mostly well-formed time tracking
    stop_target = sent + RAND_WORDS;
    seq = 0;
    while (sent < stop_target) begin
      src_idle = $urandom_range(0, 2) != 0;
      snk_idle = $urandom_range(0, 2) != 0;
      if (seq == 3) begin
        // Receiver holds off while the sender keeps offering
        hold_go  = 1'b1;
        src_idle = 1'b0;
      end
      if (seq % 12 == 11) drain();
      if (seq == 20) begin
        src_idle = 1'b0;
        snk_idle = 1'b0;
        climb(SWEEP_LEN);
      end
      case ($urandom_range(0, 9)) inside
        [0:4]: run_tracking($urandom_range(8, 40), 1'b0);
        5:     run_tracking($urandom_range(8, 40), 1'b1);
        6: begin
          for (k = 0; k < $urandom_range(1, 5); k++) begin
            send_word(1'($urandom_range(0, 1)), any6(), any6());
          end
        end
        7: climb($urandom_range(10, 40));
        8: begin
          t = $urandom_range(0, smht_pkg::SECS_PER_HOUR - 1);
          for (k = 0; k < $urandom_range(3, 10); k++) begin
            send_word(smht_pkg::CMD_TRACK, 6'(t / smht_pkg::SECS_PER_MIN),
                      6'(t % smht_pkg::SECS_PER_MIN));
          end
        end
        default: begin
          t = $urandom_range(0, smht_pkg::SECS_PER_HOUR - 1);
          for (k = 0; k < $urandom_range(1, 4); k++) begin
            send_word(smht_pkg::CMD_STOP, any6(), any6());
          end
          for (k = 0; k < $urandom_range(2, 8); k++) begin
            send_word(smht_pkg::CMD_TRACK, 6'(t / smht_pkg::SECS_PER_MIN),
                      6'(t % smht_pkg::SECS_PER_MIN));
          end
        end
      endcase
      seq++;
    end

    // Let the last results drain, then settle
    drain();
    repeat (8) @(posedge clk);

    $display("covered: %0d words (%0d stops), %0d results checked",
             sb.n_words, sb.n_stops, sb.n_results);
    $display("covered: %0d steps forward, %0d back, %0d wraps past twelve",
             sb.n_fwd, sb.n_back, sb.n_wraps);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("stepper_minute_hand_tracker_top regression: pass");
    end else begin
      $display("%0d mismatches, %0d results never came", sb.errors, sb.pending());
      $display("stepper_minute_hand_tracker_top regression: fail");
    end
    $finish;
  end

endmodule

/* stepper_minute_hand_tracker_top.f */
rtl/smht_pkg.sv
rtl/smht_in_stage.sv
rtl/smht_stepper.sv
rtl/stepper_minute_hand_tracker_top.sv
dv/tb.sv
